/* src/tbq_pkg.sv */
// ----------------------------------------------------------------------------
// tbq_pkg: shared definitions for the three-band biquad equalizer
// Sizes, coefficient codes, sequencer states and interface structs.
// ----------------------------------------------------------------------------
package tbq_pkg;

  localparam int NUM_SECTIONS  = 3;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int COEF_WIDTH    = 24;
  localparam int FRAC_BITS     = COEF_WIDTH - 4;
  localparam int COEFS_PER_SEC = 5;
  localparam int NUM_COEFS     = COEFS_PER_SEC * NUM_SECTIONS;
  localparam int CIDX_W        = $clog2(NUM_COEFS);
  localparam int SEC_W         = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int PROD_W        = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_W         = PROD_W + 3;

  localparam logic [2:0] K_B0 = 3'd0;
  localparam logic [2:0] K_B1 = 3'd1;
  localparam logic [2:0] K_B2 = 3'd2;
  localparam logic [2:0] K_A1 = 3'd3;
  localparam logic [2:0] K_A2 = 3'd4;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] x1;
    logic signed [SAMPLE_WIDTH-1:0] x2;
    logic signed [SAMPLE_WIDTH-1:0] y1;
    logic signed [SAMPLE_WIDTH-1:0] y2;
  } hist_t;

  typedef struct packed {
    logic vld;
    logic sub;
    logic clr;
  } mac_ctl_t;

  function automatic logic signed [COEF_WIDTH-1:0] coef_reset_value(
    input logic [CIDX_W-1:0] idx
  );
    logic signed [COEF_WIDTH-1:0] v;
    v = '0;
    for (int s = 0; s < NUM_SECTIONS; s++) begin
      if (idx == CIDX_W'(s * COEFS_PER_SEC)) begin
        v = COEF_ONE;
      end
    end
    return v;
  endfunction

endpackage

/* src/three_band_biquad_equalizer.sv */
// ----------------------------------------------------------------------------
// three_band_biquad_equalizer: three-section direct form I biquad cascade
// Sequences one shared multiply-accumulate unit over the coefficient and
// history stores, one coefficient per cycle.
//
//   channel  direction  handshake         payload
//   in       input      in_valid/in_stall req_type, coef_index, coef_value,
//                                         sample_in
//   out      output     out_valid/out_stall sample_out, clipped
//
// A coefficient write returns no result.
// An audio sample passes through each section in turn (5 reads, MAC drain,
// round/write-back) and then to the output register; no new item transfers
// before that. The single multiplier and the coefficient read port set this.
// Reset gives pass-through coefficients and zero history immediately.
// A stalled result holds in the output register while new items transfer.
// ----------------------------------------------------------------------------
module three_band_biquad_equalizer (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_req_type,
  input  logic [tbq_pkg::CIDX_W-1:0]              in_coef_index,
  input  logic signed [tbq_pkg::COEF_WIDTH-1:0]   in_coef_value,
  input  logic signed [tbq_pkg::SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [tbq_pkg::SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                                    out_clipped
);
  import tbq_pkg::*;

  state_t                         state_r, state_nxt;
  logic [2:0]                     k_r, k_nxt;
  logic [SEC_W-1:0]               s_r, s_nxt;
  logic [CIDX_W-1:0]              cbase_r, cbase_nxt;
  logic                           drain_r, drain_nxt;
  logic signed [SAMPLE_WIDTH-1:0] x_r, x_nxt;
  logic                           clip_r, clip_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic [2:0]                     rd_k_r, rd_k_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic                           out_clipped_r, out_clipped_nxt;

  logic                           accept;
  logic                           coef_we;
  logic                           coef_re;
  logic [CIDX_W-1:0]              coef_raddr;
  logic signed [COEF_WIDTH-1:0]   coef_rdata;
  logic                           hist_re;
  logic                           hist_we;
  hist_t                          hist_rd;
  hist_t                          hist_wd;
  mac_ctl_t                       mac_ctl;
  logic signed [SAMPLE_WIDTH-1:0] op_data;
  logic signed [SAMPLE_WIDTH-1:0] mac_y;
  logic                           mac_clip;

  tbq_coef_mem u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (coef_we),
    .waddr (in_coef_index),
    .wdata (in_coef_value),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  tbq_hist_mem u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (hist_we),
    .waddr (s_r),
    .wdata (hist_wd),
    .re    (hist_re),
    .raddr (s_r),
    .rdata (hist_rd)
  );

  tbq_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .op_coef (coef_rdata),
    .op_data (op_data),
    .y       (mac_y),
    .clip    (mac_clip)
  );

  always_comb begin
    case (rd_k_r)
      K_B0:    op_data = x_r;
      K_B1:    op_data = hist_rd.x1;
      K_B2:    op_data = hist_rd.x2;
      K_A1:    op_data = hist_rd.y1;
      K_A2:    op_data = hist_rd.y2;
      default: op_data = '0;
    endcase
  end

  assign mac_ctl.vld = rd_vld_r;
  assign mac_ctl.sub = (rd_k_r == K_A1) || (rd_k_r == K_A2);
  assign mac_ctl.clr = (state_r == ST_FINISH);

  assign hist_wd.x1 = x_r;
  assign hist_wd.x2 = hist_rd.x1;
  assign hist_wd.y1 = mac_y;
  assign hist_wd.y2 = hist_rd.y1;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && (state_r == ST_IDLE);
  assign coef_we    = accept && in_req_type &&
                      ({1'b0, in_coef_index} < (CIDX_W + 1)'(NUM_COEFS));
  assign coef_raddr = cbase_r + CIDX_W'(k_r);

  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    s_nxt           = s_r;
    cbase_nxt       = cbase_r;
    drain_nxt       = drain_r;
    x_nxt           = x_r;
    clip_nxt        = clip_r;
    rd_vld_nxt      = 1'b0;
    rd_k_nxt        = rd_k_r;
    out_valid_nxt   = out_valid_r;
    out_sample_nxt  = out_sample_r;
    out_clipped_nxt = out_clipped_r;
    coef_re         = 1'b0;
    hist_re         = 1'b0;
    hist_we         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && !in_req_type) begin
          x_nxt     = in_sample_in;
          clip_nxt  = 1'b0;
          s_nxt     = '0;
          cbase_nxt = '0;
          k_nxt     = K_B0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        coef_re    = 1'b1;
        hist_re    = (k_r == K_B0);
        rd_vld_nxt = 1'b1;
        rd_k_nxt   = k_r;
        if (k_r == K_A2) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (drain_r) begin
          state_nxt = ST_FINISH;
        end else begin
          drain_nxt = 1'b1;
        end
      end
      ST_FINISH: begin
        hist_we  = 1'b1;
        x_nxt    = mac_y;
        clip_nxt = clip_r | mac_clip;
        if (s_r == SEC_W'(NUM_SECTIONS - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          s_nxt     = s_r + SEC_W'(1);
          cbase_nxt = cbase_r + CIDX_W'(COEFS_PER_SEC);
          k_nxt     = K_B0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_sample_nxt  = x_r;
          out_clipped_nxt = clip_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= K_B0;
      s_r         <= '0;
      cbase_r     <= '0;
      drain_r     <= 1'b0;
      clip_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_k_r      <= K_B0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      s_r         <= s_nxt;
      cbase_r     <= cbase_nxt;
      drain_r     <= drain_nxt;
      clip_r      <= clip_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_k_r      <= rd_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r           <= x_nxt;
    out_sample_r  <= out_sample_nxt;
    out_clipped_r <= out_clipped_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

/* src/tbq_coef_mem.sv */
// ----------------------------------------------------------------------------
// tbq_coef_mem: coefficient store
// One write port, one registered read port; unwritten entries read as the
// pass-through default.
// ----------------------------------------------------------------------------
module tbq_coef_mem (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   we,
  input  logic [tbq_pkg::CIDX_W-1:0]             waddr,
  input  logic signed [tbq_pkg::COEF_WIDTH-1:0]  wdata,
  input  logic                                   re,
  input  logic [tbq_pkg::CIDX_W-1:0]             raddr,
  output logic signed [tbq_pkg::COEF_WIDTH-1:0]  rdata
);
  import tbq_pkg::*;

  logic signed [COEF_WIDTH-1:0] mem [NUM_COEFS];
  logic [NUM_COEFS-1:0]         vld_r;
  logic signed [COEF_WIDTH-1:0] rdata_r;
  logic signed [COEF_WIDTH-1:0] dflt_r;
  logic                         hit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
      dflt_r  <= coef_reset_value(raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        hit_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = hit_r ? rdata_r : dflt_r;

endmodule

/* src/tbq_hist_mem.sv */
// ----------------------------------------------------------------------------
// tbq_hist_mem: per-section delay-line store
// One entry per section holding x1, x2, y1, y2; unwritten entries read zero.
// ----------------------------------------------------------------------------
module tbq_hist_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [tbq_pkg::SEC_W-1:0]   waddr,
  input  tbq_pkg::hist_t              wdata,
  input  logic                        re,
  input  logic [tbq_pkg::SEC_W-1:0]   raddr,
  output tbq_pkg::hist_t              rdata
);
  import tbq_pkg::*;

  hist_t                  mem [NUM_SECTIONS];
  logic [NUM_SECTIONS-1:0] vld_r;
  hist_t                  rdata_r;
  logic                   hit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        hit_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = hit_r ? rdata_r : '0;

endmodule

/* src/tbq_mac.sv */
// ----------------------------------------------------------------------------
// tbq_mac: shared multiply-accumulate unit
// Registered product, signed accumulator, round-to-nearest and saturation.
// ----------------------------------------------------------------------------
module tbq_mac (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  tbq_pkg::mac_ctl_t                        ctl,
  input  logic signed [tbq_pkg::COEF_WIDTH-1:0]    op_coef,
  input  logic signed [tbq_pkg::SAMPLE_WIDTH-1:0]  op_data,
  output logic signed [tbq_pkg::SAMPLE_WIDTH-1:0]  y,
  output logic                                     clip
);
  import tbq_pkg::*;

  localparam int RND_W = ACC_W + 1;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] SMAX_R   = RND_W'((2 ** (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] SMIN_R   = RND_W'(-(2 ** (SAMPLE_WIDTH - 1)));

  logic signed [PROD_W-1:0] prod_r;
  logic                     pvld_r;
  logic                     psub_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  yq;

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prod_r <= op_coef * op_data;
      psub_r <= ctl.sub;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      pvld_r <= ctl.vld;
      if (ctl.clr) begin
        acc_r <= '0;
      end else if (pvld_r) begin
        if (psub_r) begin
          acc_r <= acc_r - ACC_W'(prod_r);
        end else begin
          acc_r <= acc_r + ACC_W'(prod_r);
        end
      end
    end
  end

  always_comb begin
    rnd  = RND_W'(acc_r) + RND_HALF;
    yq   = rnd >>> FRAC_BITS;
    clip = 1'b0;
    y    = yq[SAMPLE_WIDTH-1:0];
    if (yq > SMAX_R) begin
      y    = SMAX_R[SAMPLE_WIDTH-1:0];
      clip = 1'b1;
    end else if (yq < SMIN_R) begin
      y    = SMIN_R[SAMPLE_WIDTH-1:0];
      clip = 1'b1;
    end
  end

endmodule

/* src/tbq_checker.sv */
// ----------------------------------------------------------------------------
// tbq_checker: port-level checks for the biquad equalizer
// Watches the top-level handshake and output ports and is bound to every instance.
// ----------------------------------------------------------------------------
module tbq_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    in_req_type,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [tbq_pkg::SAMPLE_WIDTH-1:0] out_sample_out,
  input logic                                    out_clipped
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("outputs not cleared after reset");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_req_type) |=> in_stall)
    else $error("sample transfer did not make the block busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_sample_out) && $stable(out_clipped)))
    else $error("stalled result changed");

endmodule

bind three_band_biquad_equalizer tbq_checker u_tbq_checker (.*);
